// File: sv/edge_walk_span_table_core_macros.svh
// assertion macros for the span table checker
`ifndef EDGE_WALK_SPAN_TABLE_CORE_MACROS_SVH
`define EDGE_WALK_SPAN_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define EWST_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("span table assertion failed");

// next-cycle implication
`define EWST_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("span table assertion failed");

`endif

// File: sv/ewst_pkg.sv
package ewst_pkg;

    localparam int SCAN_LINES_DEF = 1024;
    localparam int X_BITS_DEF     = 12;
    localparam int X_IN_W         = 12;
    localparam int Y_W            = 10;
    localparam int FRAC_BITS      = 16;
    localparam int ACC_W          = X_IN_W + FRAC_BITS;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [FRAC_BITS-1:0] FRAC_FILL = '1;

    localparam logic CMD_WALK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              command;
        logic [X_IN_W-1:0] x_start;
        logic [Y_W-1:0]    y_start;
        logic [X_IN_W-1:0] x_end;
        logic [Y_W-1:0]    y_end;
        logic [Y_W-1:0]    read_row;
    } cmd_t;

    typedef struct packed {
        logic [X_IN_W-1:0] left_x;
        logic [X_IN_W-1:0] right_x;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_READ,
        OP_LEFT,
        OP_RIGHT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [Y_W-1:0]    row;
        logic [X_IN_W-1:0] x_lo;
        logic [Y_W-1:0]    dy;
        logic              dx_neg;
        logic [X_IN_W-1:0] dx_mag;
        logic              oor;
    } op_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } bk_status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ_WAIT,
        BK_DIV,
        BK_WALK
    } bk_state_t;

endpackage

// File: sv/ewst_front.sv
module ewst_front #(
    parameter int SCAN_LINES = ewst_pkg::SCAN_LINES_DEF
) (
    input  logic                   cmd_valid,
    input  ewst_pkg::cmd_t         cmd,
    input  ewst_pkg::q_status_t    q_status,
    input  ewst_pkg::bk_status_t   bk_status,
    output logic                   stall,
    output logic                   push,
    output ewst_pkg::op_entry_t    entry
);

    logic accept;
    logic swap;
    logic horizontal;
    logic [ewst_pkg::X_IN_W-1:0] x_lo;
    logic [ewst_pkg::X_IN_W-1:0] x_hi;
    logic [ewst_pkg::Y_W-1:0]    y_lo;
    logic [ewst_pkg::Y_W-1:0]    y_hi;

    assign stall  = q_status.full || bk_status.clearing;
    assign accept = cmd_valid && !stall;

    always_comb
    begin
        swap       = cmd.y_end < cmd.y_start;
        horizontal = cmd.y_end == cmd.y_start;
        x_lo       = swap ? cmd.x_end : cmd.x_start;
        x_hi       = swap ? cmd.x_start : cmd.x_end;
        y_lo       = swap ? cmd.y_end : cmd.y_start;
        y_hi       = swap ? cmd.y_start : cmd.y_end;

        entry = '0;
        push  = 1'b0;
        if (cmd.command == ewst_pkg::CMD_READ)
        begin
            entry.op  = ewst_pkg::OP_READ;
            entry.row = cmd.read_row;
            entry.oor = int'(cmd.read_row) >= SCAN_LINES;
            push      = accept;
        end
        else
        begin
            entry.op     = swap ? ewst_pkg::OP_RIGHT : ewst_pkg::OP_LEFT;
            entry.row    = y_lo;
            entry.x_lo   = x_lo;
            entry.dy     = y_hi - y_lo;
            entry.dx_neg = x_hi < x_lo;
            entry.dx_mag = (x_hi < x_lo) ? (x_lo - x_hi) : (x_hi - x_lo);
            // horizontal edges are dropped here
            push         = accept && !horizontal;
        end
    end

endmodule

// File: sv/ewst_queue.sv
module ewst_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ewst_pkg::op_entry_t   push_entry,
    input  logic                  pop,
    output ewst_pkg::op_entry_t   head,
    output ewst_pkg::q_status_t   status
);

    localparam int PTR_W = $clog2(ewst_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ewst_pkg::QUEUE_DEPTH + 1);

    ewst_pkg::op_entry_t entries_reg [ewst_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = count_reg == CNT_W'(ewst_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/ewst_div.sv
module ewst_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ewst_pkg::ACC_W-1:0]  dividend,
    input  logic [ewst_pkg::Y_W-1:0]    divisor,
    output logic                        done,
    output logic [ewst_pkg::ACC_W-1:0]  quotient
);

    localparam int ACC_W = ewst_pkg::ACC_W;
    localparam int Y_W   = ewst_pkg::Y_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [Y_W-1:0]   rem_reg, rem_next;
    logic [Y_W-1:0]   div_reg, div_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [Y_W:0] trial;
    logic [Y_W:0] diff;
    logic         ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[ACC_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[Y_W-1:0] : trial[Y_W-1:0];
            quo_next = {quo_reg[ACC_W-2:0], ge};
            cnt_next = CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

// File: sv/ewst_back.sv
module ewst_back #(
    parameter int SCAN_LINES = ewst_pkg::SCAN_LINES_DEF,
    parameter int X_BITS     = ewst_pkg::X_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ewst_pkg::op_entry_t   head,
    input  ewst_pkg::q_status_t   q_status,
    output logic                  pop,
    output ewst_pkg::bk_status_t  status,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ewst_pkg::rsp_t        rsp
);

    localparam int ROW_W     = $clog2(SCAN_LINES);
    localparam int ACC_W     = ewst_pkg::ACC_W;
    localparam int Y_W       = ewst_pkg::Y_W;
    localparam int X_IN_W    = ewst_pkg::X_IN_W;
    localparam int FRAC_BITS = ewst_pkg::FRAC_BITS;

    ewst_pkg::bk_state_t state_reg, state_next;

    logic [ROW_W-1:0]  clr_reg, clr_next;
    logic [Y_W-1:0]    row_reg, row_next;
    logic [Y_W-1:0]    rows_left_reg, rows_left_next;
    logic              side_reg, side_next;
    logic              neg_reg, neg_next;
    logic              oor_reg, oor_next;
    logic [X_IN_W-1:0] x_lo_reg, x_lo_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  slope_reg, slope_next;
    logic              rsp_valid_reg, rsp_valid_next;
    ewst_pkg::rsp_t    rsp_reg, rsp_next;

    logic [X_BITS-1:0] row_left_mem  [SCAN_LINES];
    logic [X_BITS-1:0] row_right_mem [SCAN_LINES];
    logic [X_BITS-1:0] left_rd_reg;
    logic [X_BITS-1:0] right_rd_reg;

    logic              wr_left;
    logic              wr_right;
    logic [ROW_W-1:0]  wr_addr;
    logic [X_BITS-1:0] wr_data;
    logic [ROW_W-1:0]  rd_addr;
    logic              slot_free;
    logic              in_range;

    logic              div_start;
    logic              div_done;
    logic [ACC_W-1:0]  div_quo;

    ewst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({head.dx_mag, {FRAC_BITS{1'b0}}}),
        .divisor  (head.dy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign status.clearing = state_reg == ewst_pkg::BK_CLEAR;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        row_next       = row_reg;
        rows_left_next = rows_left_reg;
        side_next      = side_reg;
        neg_next       = neg_reg;
        oor_next       = oor_reg;
        x_lo_next      = x_lo_reg;
        acc_next       = acc_reg;
        slope_next     = slope_reg;
        rsp_next       = rsp_reg;

        slot_free      = !rsp_valid_reg || !rsp_stall;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        in_range       = int'(row_reg) < SCAN_LINES;

        pop       = 1'b0;
        div_start = 1'b0;
        wr_left   = 1'b0;
        wr_right  = 1'b0;
        wr_addr   = ROW_W'(row_reg);
        wr_data   = X_BITS'(acc_reg[ACC_W-1:FRAC_BITS]);
        rd_addr   = ROW_W'(head.row);

        case (state_reg)
            ewst_pkg::BK_CLEAR:
            begin
                wr_left  = 1'b1;
                wr_right = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = ROW_W'(clr_reg + 1'b1);
                if (clr_reg == ROW_W'(SCAN_LINES - 1))
                begin
                    state_next = ewst_pkg::BK_IDLE;
                end
            end
            ewst_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    case (head.op)
                        ewst_pkg::OP_READ:
                        begin
                            if (slot_free)
                            begin
                                pop        = 1'b1;
                                oor_next   = head.oor;
                                state_next = ewst_pkg::BK_READ_WAIT;
                            end
                        end
                        ewst_pkg::OP_LEFT, ewst_pkg::OP_RIGHT:
                        begin
                            pop            = 1'b1;
                            div_start      = 1'b1;
                            row_next       = head.row;
                            rows_left_next = head.dy;
                            side_next      = head.op == ewst_pkg::OP_RIGHT;
                            neg_next       = head.dx_neg;
                            x_lo_next      = head.x_lo;
                            state_next     = ewst_pkg::BK_DIV;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ewst_pkg::BK_READ_WAIT:
            begin
                rsp_valid_next = 1'b1;
                if (oor_reg)
                begin
                    rsp_next = '0;
                end
                else
                begin
                    rsp_next.left_x  = X_IN_W'(left_rd_reg);
                    rsp_next.right_x = X_IN_W'(right_rd_reg);
                end
                state_next = ewst_pkg::BK_IDLE;
            end
            ewst_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    slope_next = neg_reg ? ACC_W'(~div_quo + 1'b1) : div_quo;
                    acc_next   = {x_lo_reg, ewst_pkg::FRAC_FILL};
                    state_next = ewst_pkg::BK_WALK;
                end
            end
            ewst_pkg::BK_WALK:
            begin
                wr_left  = in_range && !side_reg;
                wr_right = in_range && side_reg;
                // accumulator stays in range, so modular add is exact
                acc_next = ACC_W'(acc_reg + slope_reg);
                row_next = Y_W'(row_reg + 1'b1);
                if (rows_left_reg == '0)
                begin
                    state_next = ewst_pkg::BK_IDLE;
                end
                else
                begin
                    rows_left_next = Y_W'(rows_left_reg - 1'b1);
                end
            end
            default:
            begin
                state_next = ewst_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ewst_pkg::BK_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        rows_left_reg <= rows_left_next;
        side_reg      <= side_next;
        neg_reg       <= neg_next;
        oor_reg       <= oor_next;
        x_lo_reg      <= x_lo_next;
        acc_reg       <= acc_next;
        slope_reg     <= slope_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            row_left_mem[wr_addr] <= wr_data;
        end
        if (wr_right)
        begin
            row_right_mem[wr_addr] <= wr_data;
        end
        left_rd_reg  <= row_left_mem[rd_addr];
        right_rd_reg <= row_right_mem[rd_addr];
    end

endmodule

// File: sv/edge_walk_span_table_core.sv
// span table core: walks polygon edges into per-scanline left/right x bounds
// cmd channel (cmd_valid/cmd_stall/cmd): walk an edge or read one row
// rsp channel (rsp_valid/rsp_stall/rsp): left_x and right_x of a read row
// a transaction moves when valid is high and stall is low
// commands go through a two-entry queue, so cmd keeps flowing while a
// read result waits in the output register
// read: BK_IDLE pops it and registers the table row, BK_READ_WAIT loads rsp
// edge: serial slope divider, then one table write per scanline; the back end
// takes one command at a time; horizontal edges cost no back-end time
// reads wait behind earlier edges, so they always see the finished table
// reset: a sweep clears both tables over all SCAN_LINES rows, one row a
// cycle; cmd_stall stays high for the whole sweep
// while rsp_stall is high the result holds, and further reads wait in the
// queue; cmd_stall rises once the queue is full
module edge_walk_span_table_core #(
    parameter int SCAN_LINES = ewst_pkg::SCAN_LINES_DEF,
    parameter int X_BITS     = ewst_pkg::X_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  ewst_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ewst_pkg::rsp_t  rsp
);

    ewst_pkg::q_status_t  q_status;
    ewst_pkg::bk_status_t bk_status;
    ewst_pkg::op_entry_t  push_entry;
    ewst_pkg::op_entry_t  head;
    logic                 push;
    logic                 pop;

    ewst_front #(
        .SCAN_LINES (SCAN_LINES)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .q_status  (q_status),
        .bk_status (bk_status),
        .stall     (cmd_stall),
        .push      (push),
        .entry     (push_entry)
    );

    ewst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    ewst_back #(
        .SCAN_LINES (SCAN_LINES),
        .X_BITS     (X_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .status    (bk_status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: sv/ewst_checker.sv
`include "edge_walk_span_table_core_macros.svh"

module ewst_checker #(
    parameter int X_BITS = ewst_pkg::X_BITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input ewst_pkg::rsp_t rsp
);

    // stalled result holds
    `EWST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // result leaves only through a transaction
    `EWST_ASSERT_NOW(a_rsp_drop, $fell(rsp_valid), $past(!rsp_stall))

    // clearing sweep blocks commands and no result comes out of reset
    `EWST_ASSERT_NOW(a_reset_sweep, $past(!rst_n), cmd_stall && !rsp_valid)

    // stored bounds never exceed the table width
    `EWST_ASSERT_NOW(a_rsp_width, rsp_valid,
        ((32'(rsp.left_x) | 32'(rsp.right_x)) >> X_BITS) == 32'd0)

endmodule

bind edge_walk_span_table_core ewst_checker #(
    .X_BITS (X_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
